// File: hw/rtl/dqs_pkg.sv
`default_nettype none

package dqs_pkg;

  // Capacity of the ring buffer (1 .. 31; the response count is COUNT_W bits)
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned COUNT_W = 5;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_EXISTS     = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // Start of a search walk
  typedef struct packed {
    logic  start;
    ptr_t  head;
    cnt_t  count;
    data_t value;
  } scan_cmd_t;

  // Search walk status
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } scan_stat_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_inc = (p == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    ptr_dec = (p == '0) ? ptr_t'(DEPTH - 1) : ptr_t'(p - 1'b1);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dqs_req_if.sv
`default_nettype none

interface dqs_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] data_value;

  modport source (output valid, output req_type, output data_value, input ready);
  modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dqs_rsp_if.sv
`default_nettype none

interface dqs_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic       found;
  logic [4:0] entry_count;

  modport source (output valid, output ok, output found, output entry_count, input ready);
  modport sink   (input valid, input ok, input found, input entry_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dqs_ram.sv
`default_nettype none

module dqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/dqs_scan.sv
`default_nettype none

module dqs_scan (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dqs_pkg::scan_cmd_t cmd_i,
  input  wire dqs_pkg::data_t     rdata_i,
  output dqs_pkg::ptr_t           raddr_o,
  output dqs_pkg::scan_stat_t     stat_o
);
  import dqs_pkg::*;

  logic  busy_q;
  logic  rd_vld_q;
  logic  found_q, found_d;
  cnt_t  idx_q;
  cnt_t  cnt_q;
  ptr_t  addr_q;
  data_t val_q;
  logic  issue;
  logic  hit;

  // Issue one read per cycle from head toward tail; compare in the cycle after each read
  assign issue = busy_q && (idx_q < cnt_q);
  assign hit   = rd_vld_q && (rdata_i == val_q);

  always_comb begin
    found_d = found_q | hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.start) begin
      busy_q   <= 1'b1;
      rd_vld_q <= 1'b0;
    end else if (busy_q) begin
      rd_vld_q <= issue;
      if (!issue && !rd_vld_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      idx_q   <= '0;
      cnt_q   <= cmd_i.count;
      addr_q  <= cmd_i.head;
      val_q   <= cmd_i.value;
      found_q <= 1'b0;
    end else if (busy_q) begin
      found_q <= found_d;
      if (issue) begin
        idx_q  <= cnt_t'(idx_q + 1'b1);
        addr_q <= ptr_inc(addr_q);
      end
    end
  end

  assign raddr_o      = addr_q;
  assign stat_o.busy  = busy_q;
  assign stat_o.done  = busy_q && !issue && !rd_vld_q;
  assign stat_o.found = found_q;

endmodule

`default_nettype wire

// File: hw/rtl/bounded_deque_with_search.sv
// Flow: push, pop, clear and unused codes pass from the input transfer through
//   ST_RESP into the output register; exists first walks the stored entries in
//   ST_SCAN, then passes through ST_RESP.
// Throughput: one request at a time; the memory's single read port walks the
//   stored entries one per cycle during exists, and a new request is taken once the
//   previous result is in the output register.
// Reset: head, tail and count return to zero; the entry memory is not cleared.
`default_nettype none

module bounded_deque_with_search (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dqs_req_if.sink   req,
  dqs_rsp_if.source rsp
);
  import dqs_pkg::*;

  state_e     state_q, state_d;
  ptr_t       head_q, head_d;
  ptr_t       tail_q, tail_d;
  cnt_t       cnt_q, cnt_d;
  logic       ok_d;
  logic       we;
  ptr_t       waddr;
  ptr_t       raddr;
  data_t      rdata;
  logic       accept;
  logic       is_exists;
  logic       out_load;
  scan_cmd_t  scan_cmd;
  scan_stat_t scan_stat;

  // Pending result, held until the output register takes it
  logic res_ok_q;
  logic res_found_q;
  cnt_t res_cnt_q;

  // Output register
  logic                 out_valid_q;
  logic                 out_ok_q;
  logic                 out_found_q;
  logic [COUNT_W-1:0]   out_cnt_q;

  assign accept    = req.valid && req.ready;
  assign is_exists = (req.req_type == REQ_EXISTS);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = is_exists ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || rsp.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req.ready = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: ;
      ST_RESP: out_load = !out_valid_q || rsp.ready;
      default: ;
    endcase
  end

  // Request decode: pointer and count update, memory write
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    ok_d   = 1'b0;
    we     = 1'b0;
    waddr  = tail_q;
    case (req.req_type)
      REQ_PUSH_FRONT: begin
        if (cnt_q < cnt_t'(DEPTH)) begin
          head_d = ptr_dec(head_q);
          waddr  = head_d;
          we     = accept;
          cnt_d  = cnt_t'(cnt_q + 1'b1);
          ok_d   = 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (cnt_q < cnt_t'(DEPTH)) begin
          waddr  = tail_q;
          we     = accept;
          tail_d = ptr_inc(tail_q);
          cnt_d  = cnt_t'(cnt_q + 1'b1);
          ok_d   = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (cnt_q != '0) begin
          head_d = ptr_inc(head_q);
          cnt_d  = cnt_t'(cnt_q - 1'b1);
          ok_d   = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (cnt_q != '0) begin
          tail_d = ptr_dec(tail_q);
          cnt_d  = cnt_t'(cnt_q - 1'b1);
          ok_d   = 1'b1;
        end
      end
      REQ_EXISTS: ok_d = 1'b1;
      REQ_CLEAR: begin
        head_d = '0;
        tail_d = '0;
        cnt_d  = '0;
        ok_d   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        head_q <= head_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_ok_q    <= ok_d;
      res_found_q <= 1'b0;
      res_cnt_q   <= cnt_d;
    end else if (state_q == ST_SCAN && scan_stat.done) begin
      res_found_q <= scan_stat.found;
    end
    if (out_load) begin
      out_ok_q    <= res_ok_q;
      out_found_q <= res_found_q;
      out_cnt_q   <= COUNT_W'(res_cnt_q);
    end
  end

  // Search walk starts from the current head over the stored entries
  assign scan_cmd.start = accept && is_exists;
  assign scan_cmd.head  = head_q;
  assign scan_cmd.count = cnt_q;
  assign scan_cmd.value = data_t'(req.data_value);

  dqs_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (scan_cmd),
    .rdata_i (rdata),
    .raddr_o (raddr),
    .stat_o  (scan_stat)
  );

  // Writes happen only at transfer, read data is used only while scanning: never overlapping
  dqs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (data_t'(req.data_value)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rsp.valid       = out_valid_q;
  assign rsp.ok          = out_ok_q;
  assign rsp.found       = out_found_q;
  assign rsp.entry_count = out_cnt_q;

endmodule

`default_nettype wire
